// ===== rtl/core/rcbm_pkg.sv =====
// Shared types, widths and codes of the region checked byte memory.
package rcbm_pkg;

  localparam int unsigned REGION_COUNT_DEF = 8;
  localparam int unsigned ADDRESS_BITS_DEF = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned FLAGS_W  = 3;
  localparam int unsigned NBYTES_W = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned MAX_ACCESS = 8;
  localparam int unsigned LANES      = 8;
  localparam int unsigned LANE_BITS  = 3;

  localparam int unsigned PERM_X_BIT = 0;
  localparam int unsigned PERM_W_BIT = 1;
  localparam int unsigned PERM_R_BIT = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_REGION = 3'd1,
    ST_NO_READ   = 3'd2,
    ST_NO_EXEC   = 3'd3,
    ST_NO_WRITE  = 3'd4,
    ST_OVERLAP   = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    cmd_e                command;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    region_length;
    logic [FLAGS_W-1:0]  region_flags;
    logic [NBYTES_W-1:0] nbytes;
    logic                fetch;
    logic [DATA_W-1:0]   write_data;
  } item_t;

endpackage

// ===== rtl/core/rcbm_req_if.sv =====
// Request channel carrying one memory or region command per transaction.
interface rcbm_req_if;
  logic                          valid;
  logic                          ready;
  logic [rcbm_pkg::CMD_W-1:0]    command;
  logic [rcbm_pkg::ADDR_W-1:0]   addr;
  logic [rcbm_pkg::LEN_W-1:0]    region_length;
  logic [rcbm_pkg::FLAGS_W-1:0]  region_flags;
  logic [rcbm_pkg::NBYTES_W-1:0] access_bytes;
  logic                          fetch;
  logic [rcbm_pkg::DATA_W-1:0]   write_data;

  modport source (
    output valid, command, addr, region_length, region_flags, access_bytes, fetch,
           write_data,
    input  ready
  );

  modport sink (
    input  valid, command, addr, region_length, region_flags, access_bytes, fetch,
           write_data,
    output ready
  );
endinterface

// ===== rtl/core/rcbm_rsp_if.sv =====
// Response channel carrying read data and status per transaction.
interface rcbm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rcbm_pkg::DATA_W-1:0]   read_data;
  logic [rcbm_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, read_data, status,
    input  ready
  );

  modport sink (
    input  valid, read_data, status,
    output ready
  );
endinterface

// ===== rtl/core/region_checked_byte_memory_unit.sv =====
// Byte memory guarded by a region table with read, write and execute permissions.
//
// The request channel req_i takes one command per transaction: insert a
// region, read (optionally as an instruction fetch), write, or load without
// a permission check. Every request gives exactly one transaction on the
// response channel rsp_o, carrying the little-endian read data and a status.
// When a request is taken, all region entries are compared against its
// address and the eight byte lanes of the store are read. In the execute
// state the block resolves the permission and, once the output register
// is free, writes the byte lanes or the region table and loads the output
// register. No new request is taken until the block is idle again. The
// output register lets a request be taken while a response still waits;
// if the receiver stalls, the block holds the finished item in its
// execute state until the output register frees up. Reset empties the
// region table and the output register. The byte store is not cleared,
// and reading a byte that was never written returns an arbitrary value.
module region_checked_byte_memory_unit #(
  parameter int unsigned REGION_COUNT = rcbm_pkg::REGION_COUNT_DEF,
  parameter int unsigned ADDRESS_BITS = rcbm_pkg::ADDRESS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcbm_req_if.sink   req_i,
  rcbm_rsp_if.source rsp_o
);

  localparam int unsigned ADDR_W   = rcbm_pkg::ADDR_W;
  localparam int unsigned END_W    = ADDR_W + 1;
  localparam int unsigned LB       = rcbm_pkg::LANE_BITS;
  localparam int unsigned ROW_BITS = ADDRESS_BITS - LB;
  localparam int unsigned ROWS     = 2 ** ROW_BITS;
  localparam int unsigned IDX_BITS = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int unsigned NB_W     = rcbm_pkg::NBYTES_W;

  rcbm_pkg::fsm_e  fsm_q, fsm_d;
  rcbm_pkg::item_t item_q;

  logic accept;
  logic exec_go;

  logic [ADDRESS_BITS-1:0] in_full;
  logic [ADDR_W-1:0]       in_addr;
  logic [END_W-1:0]        in_end;
  logic [NB_W-1:0]         in_nbytes;
  logic [ADDRESS_BITS-1:0] it_full;

  logic [REGION_COUNT-1:0] valid_q;
  logic [ADDR_W-1:0]       base_q [REGION_COUNT];
  logic [ADDR_W-1:0]       size_q [REGION_COUNT];
  logic [2:0]              perm_q [REGION_COUNT];
  logic [END_W-1:0]        reg_end [REGION_COUNT];

  logic [REGION_COUNT-1:0] hit_d, hit_q;
  logic [REGION_COUNT-1:0] ovl_d, ovl_q;

  logic [IDX_BITS-1:0] hit_idx;
  logic [IDX_BITS-1:0] free_idx;
  logic [2:0]          hit_perm;
  logic                any_hit;
  logic                table_full;

  rcbm_pkg::status_e status_d;
  logic              do_insert;
  logic              do_store;
  logic              do_read;

  logic [7:0] rdat_q [rcbm_pkg::LANES];
  logic [rcbm_pkg::DATA_W-1:0] rdata_d;

  logic                        out_valid_q;
  logic [rcbm_pkg::DATA_W-1:0] out_data_q;
  rcbm_pkg::status_e           out_status_q;

  assign req_i.ready = (fsm_q == rcbm_pkg::FSM_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign exec_go     = (fsm_q == rcbm_pkg::FSM_EXEC) && (!out_valid_q || rsp_o.ready);

  assign in_full   = ADDRESS_BITS'(req_i.addr);
  assign in_addr   = ADDR_W'(in_full);
  assign in_end    = {1'b0, in_addr} + {1'b0, req_i.region_length};
  assign in_nbytes = (req_i.access_bytes > NB_W'(rcbm_pkg::MAX_ACCESS)) ?
                     NB_W'(rcbm_pkg::MAX_ACCESS) : req_i.access_bytes;
  assign it_full   = ADDRESS_BITS'(item_q.addr);

  always_comb begin
    for (int i = 0; i < REGION_COUNT; i++) begin
      reg_end[i] = {1'b0, base_q[i]} + {1'b0, size_q[i]};
      hit_d[i]   = valid_q[i] && (in_addr >= base_q[i]) && ({1'b0, in_addr} <= reg_end[i]);
      ovl_d[i]   = valid_q[i] && !((in_end < {1'b0, base_q[i]}) ||
                                   ({1'b0, in_addr} > reg_end[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command       <= rcbm_pkg::cmd_e'(req_i.command);
      item_q.addr          <= in_addr;
      item_q.region_length <= req_i.region_length;
      item_q.region_flags  <= req_i.region_flags;
      item_q.nbytes        <= in_nbytes;
      item_q.fetch         <= req_i.fetch;
      item_q.write_data    <= req_i.write_data;
      hit_q                <= hit_d;
      ovl_q                <= ovl_d;
    end
  end

  for (genvar j = 0; j < rcbm_pkg::LANES; j++) begin : g_lane
    logic [7:0]          mem [ROWS];
    logic [ROW_BITS-1:0] rd_row;
    logic [ROW_BITS-1:0] wr_row;
    logic [LB-1:0]       k;
    logic                we;
    logic [7:0]          wdat;

    assign rd_row = in_full[ADDRESS_BITS-1:LB] + ROW_BITS'(LB'(j) < in_full[LB-1:0]);
    assign wr_row = it_full[ADDRESS_BITS-1:LB] + ROW_BITS'(LB'(j) < it_full[LB-1:0]);
    assign k      = LB'(j) - it_full[LB-1:0];
    assign we     = exec_go && do_store && ({1'b0, k} < item_q.nbytes);
    assign wdat   = 8'(item_q.write_data >> {k, 3'b000});

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[wr_row] <= wdat;
      end
      if (accept) begin
        rdat_q[j] <= mem[rd_row];
      end
    end
  end

  always_comb begin
    logic [LB-1:0] lane;
    rdata_d = '0;
    for (int k = 0; k < rcbm_pkg::LANES; k++) begin
      lane = LB'(k) + it_full[LB-1:0];
      if (NB_W'(k) < item_q.nbytes) begin
        rdata_d[8*k +: 8] = rdat_q[lane];
      end
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = REGION_COUNT - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IDX_BITS'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign any_hit    = |hit_q;
  assign table_full = &valid_q;
  assign hit_perm   = perm_q[hit_idx];

  always_comb begin
    status_d  = rcbm_pkg::ST_OK;
    do_insert = 1'b0;
    do_store  = 1'b0;
    do_read   = 1'b0;
    unique case (item_q.command)
      rcbm_pkg::CMD_INSERT: begin
        if (|ovl_q) begin
          status_d = rcbm_pkg::ST_OVERLAP;
        end else if (table_full) begin
          status_d = rcbm_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      rcbm_pkg::CMD_READ: begin
        if (!any_hit) begin
          status_d = rcbm_pkg::ST_NO_REGION;
        end else if (!hit_perm[rcbm_pkg::PERM_R_BIT]) begin
          status_d = rcbm_pkg::ST_NO_READ;
        end else if (item_q.fetch && !hit_perm[rcbm_pkg::PERM_X_BIT]) begin
          status_d = rcbm_pkg::ST_NO_EXEC;
        end else begin
          do_read = 1'b1;
        end
      end
      rcbm_pkg::CMD_WRITE: begin
        if (!any_hit) begin
          status_d = rcbm_pkg::ST_NO_REGION;
        end else if (!hit_perm[rcbm_pkg::PERM_W_BIT]) begin
          status_d = rcbm_pkg::ST_NO_WRITE;
        end else begin
          do_store = 1'b1;
        end
      end
      rcbm_pkg::CMD_LOAD: begin
        do_store = 1'b1;
      end
      default: begin
        status_d = rcbm_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (exec_go && do_insert) begin
      valid_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go && do_insert) begin
      base_q[free_idx] <= item_q.addr;
      size_q[free_idx] <= item_q.region_length;
      perm_q[free_idx] <= item_q.region_flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= rcbm_pkg::FSM_IDLE;
    end else begin
      fsm_q <= fsm_d;
    end
  end

  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      rcbm_pkg::FSM_IDLE: begin
        if (accept) begin
          fsm_d = rcbm_pkg::FSM_EXEC;
        end
      end
      rcbm_pkg::FSM_EXEC: begin
        if (exec_go) begin
          fsm_d = rcbm_pkg::FSM_IDLE;
        end
      end
      default: begin
        fsm_d = rcbm_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_data_q   <= do_read ? rdata_d : '0;
      out_status_q <= status_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_o.status    = out_status_q;

endmodule

// ===== rtl/core/rcbm_checker.sv =====
// Port-level checks of the region checked byte memory and their binding.
module rcbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  rcbm_req_if.sink   req_i,
  rcbm_rsp_if.source rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=>
      rsp_o.valid && $stable(rsp_o.read_data) && $stable(rsp_o.status))
    else $error("Response changed while stalled.");

  a_req_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("Request taken in the cycle after another request.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != rcbm_pkg::ST_OK) |-> rsp_o.read_data == '0)
    else $error("Failed transaction returned nonzero read data.");

  a_rsp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(req_i.valid && req_i.ready, 2))
    else $error("Response appeared without a request two cycles earlier.");

endmodule

bind region_checked_byte_memory_unit rcbm_checker u_rcbm_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req_i (req_i),
  .rsp_o (rsp_o)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the region checked byte memory unit.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_ITEMS   = 900;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam bit [rcbm_pkg::FLAGS_W-1:0] ALLOW_NONE = '0;
  localparam bit [rcbm_pkg::FLAGS_W-1:0] ALLOW_X    =
    rcbm_pkg::FLAGS_W'(1 << rcbm_pkg::PERM_X_BIT);
  localparam bit [rcbm_pkg::FLAGS_W-1:0] ALLOW_W    =
    rcbm_pkg::FLAGS_W'(1 << rcbm_pkg::PERM_W_BIT);
  localparam bit [rcbm_pkg::FLAGS_W-1:0] ALLOW_R    =
    rcbm_pkg::FLAGS_W'(1 << rcbm_pkg::PERM_R_BIT);

  typedef struct {
    bit [rcbm_pkg::DATA_W-1:0] read_data;
    rcbm_pkg::status_e         status;
  } memory_response_t;

  class region_memory_scoreboard;
    bit                         region_used [rcbm_pkg::REGION_COUNT_DEF];
    bit [rcbm_pkg::ADDR_W-1:0]  region_base [rcbm_pkg::REGION_COUNT_DEF];
    bit [rcbm_pkg::LEN_W-1:0]   region_size [rcbm_pkg::REGION_COUNT_DEF];
    bit [rcbm_pkg::FLAGS_W-1:0] region_perm [rcbm_pkg::REGION_COUNT_DEF];
    bit [7:0]                   store_bytes [2**rcbm_pkg::ADDR_W];
    bit                         store_written [2**rcbm_pkg::ADDR_W];
    memory_response_t           awaited_responses [$];
    int unsigned                errors;

    function new();
      errors = 0;
    endfunction

    function bit [rcbm_pkg::ADDR_W-1:0] lane_addr(bit [rcbm_pkg::ADDR_W-1:0] a,
                                                  int unsigned lane);
      return a + rcbm_pkg::ADDR_W'(lane);
    endfunction

    function int unsigned access_count(rcbm_pkg::item_t r);
      return (r.nbytes > rcbm_pkg::MAX_ACCESS) ? rcbm_pkg::MAX_ACCESS : r.nbytes;
    endfunction

    function int unsigned region_end(int unsigned i);
      return region_base[i] + region_size[i];
    endfunction

    function int find_region(bit [rcbm_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < rcbm_pkg::REGION_COUNT_DEF; i++) begin
        if (region_used[i] && a >= region_base[i] && a <= region_end(i)) return i;
      end
      return -1;
    endfunction

    function rcbm_pkg::status_e insert_region(rcbm_pkg::item_t r);
      int slot;
      int unsigned new_end;
      slot = -1;
      new_end = r.addr + r.region_length;
      for (int i = 0; i < rcbm_pkg::REGION_COUNT_DEF; i++) begin
        if (region_used[i] && !(new_end < region_base[i] || r.addr > region_end(i)))
          return rcbm_pkg::ST_OVERLAP;
      end
      for (int i = 0; i < rcbm_pkg::REGION_COUNT_DEF; i++) begin
        if (!region_used[i] && slot < 0) slot = i;
      end
      if (slot < 0) return rcbm_pkg::ST_FULL;
      region_used[slot] = 1'b1;
      region_base[slot] = r.addr;
      region_size[slot] = r.region_length;
      region_perm[slot] = r.region_flags;
      return rcbm_pkg::ST_OK;
    endfunction

    function void write_bytes(bit [rcbm_pkg::ADDR_W-1:0] a, int unsigned n,
                              bit [rcbm_pkg::DATA_W-1:0] d);
      for (int unsigned i = 0; i < n; i++) begin
        store_bytes[lane_addr(a, i)] = d[8*i +: 8];
        store_written[lane_addr(a, i)] = 1'b1;
      end
    endfunction

    function memory_response_t predict_response(rcbm_pkg::item_t r);
      memory_response_t rsp;
      int hit;
      int unsigned n;
      rsp.read_data = '0;
      rsp.status = rcbm_pkg::ST_OK;
      n = access_count(r);
      hit = find_region(r.addr);
      case (r.command)
        rcbm_pkg::CMD_INSERT: rsp.status = insert_region(r);
        rcbm_pkg::CMD_READ: begin
          if (hit < 0) rsp.status = rcbm_pkg::ST_NO_REGION;
          else if (!region_perm[hit][rcbm_pkg::PERM_R_BIT]) rsp.status = rcbm_pkg::ST_NO_READ;
          else if (r.fetch && !region_perm[hit][rcbm_pkg::PERM_X_BIT])
            rsp.status = rcbm_pkg::ST_NO_EXEC;
          else begin
            for (int unsigned i = 0; i < n; i++)
              rsp.read_data[8*i +: 8] = store_bytes[lane_addr(r.addr, i)];
          end
        end
        rcbm_pkg::CMD_WRITE: begin
          if (hit < 0) rsp.status = rcbm_pkg::ST_NO_REGION;
          else if (!region_perm[hit][rcbm_pkg::PERM_W_BIT]) rsp.status = rcbm_pkg::ST_NO_WRITE;
          else write_bytes(r.addr, n, r.write_data);
        end
        default: write_bytes(r.addr, n, r.write_data);
      endcase
      return rsp;
    endfunction

    // A read is only issued once every byte it returns has been stored.
    function bit reads_unwritten(rcbm_pkg::item_t r);
      memory_response_t outcome;
      if (r.command != rcbm_pkg::CMD_READ) return 1'b0;
      outcome = predict_response(r);
      if (outcome.status != rcbm_pkg::ST_OK) return 1'b0;
      for (int unsigned i = 0; i < access_count(r); i++) begin
        if (!store_written[lane_addr(r.addr, i)]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(rcbm_pkg::item_t r);
      awaited_responses.push_back(predict_response(r));
    endfunction

    function void check_response(logic [rcbm_pkg::DATA_W-1:0] data,
                                 logic [rcbm_pkg::STATUS_W-1:0] status);
      memory_response_t want;
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual read_data %h status %0d",
                 $time, data, status);
        errors++;
        return;
      end
      want = awaited_responses.pop_front();
      if (data !== want.read_data) begin
        $display("%0t: read_data mismatch, expected %h, actual %h",
                 $time, want.read_data, data);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   gaps_on = 1'b1;

  region_memory_scoreboard sb;

  rcbm_req_if req_bus ();
  rcbm_rsp_if rsp_bus ();

  region_checked_byte_memory_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready = !gaps_on || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      sb.check_response(rsp_bus.read_data, rsp_bus.status);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("region_checked_byte_memory_unit test failed");
    $finish;
  end

  function automatic rcbm_pkg::item_t make_access(rcbm_pkg::cmd_e c,
                                                  bit [rcbm_pkg::ADDR_W-1:0] a,
                                                  bit [rcbm_pkg::NBYTES_W-1:0] n,
                                                  bit f, bit [rcbm_pkg::DATA_W-1:0] d);
    rcbm_pkg::item_t r;
    r.command       = c;
    r.addr          = a;
    r.region_length = rcbm_pkg::LEN_W'($urandom);
    r.region_flags  = rcbm_pkg::FLAGS_W'($urandom);
    r.nbytes        = n;
    r.fetch         = f;
    r.write_data    = d;
    return r;
  endfunction

  function automatic rcbm_pkg::item_t make_insert(bit [rcbm_pkg::ADDR_W-1:0] a,
                                                  bit [rcbm_pkg::LEN_W-1:0] len,
                                                  bit [rcbm_pkg::FLAGS_W-1:0] flags);
    rcbm_pkg::item_t r;
    r.command       = rcbm_pkg::CMD_INSERT;
    r.addr          = a;
    r.region_length = len;
    r.region_flags  = flags;
    r.nbytes        = rcbm_pkg::NBYTES_W'($urandom);
    r.fetch         = 1'($urandom);
    r.write_data    = {$urandom, $urandom};
    return r;
  endfunction

  // Addresses mostly land inside or right at the edges of known regions.
  function automatic rcbm_pkg::item_t random_item();
    int unsigned pick;
    int unsigned k;
    bit [rcbm_pkg::ADDR_W-1:0] a;
    bit [rcbm_pkg::NBYTES_W-1:0] n;
    bit [rcbm_pkg::LEN_W-1:0] len;
    pick = $urandom_range(99);
    k = $urandom_range(rcbm_pkg::REGION_COUNT_DEF - 1);
    case ($urandom_range(9))
      0: a = rcbm_pkg::ADDR_W'($urandom);
      1: a = sb.region_base[k] - 16'd1;
      2: a = rcbm_pkg::ADDR_W'(sb.region_end(k) + 1);
      3: a = rcbm_pkg::ADDR_W'(sb.region_end(k));
      default: a = sb.region_base[k] + rcbm_pkg::ADDR_W'($urandom_range(sb.region_size[k]));
    endcase
    n = ($urandom_range(99) < 15) ? rcbm_pkg::NBYTES_W'($urandom_range(15))
                                  : rcbm_pkg::NBYTES_W'($urandom_range(rcbm_pkg::MAX_ACCESS, 1));
    len = ($urandom_range(1) == 0) ? rcbm_pkg::LEN_W'($urandom_range(255))
                                   : rcbm_pkg::LEN_W'($urandom);
    if (pick < 10) return make_insert(a, len, rcbm_pkg::FLAGS_W'($urandom));
    if (pick < 55)
      return make_access(rcbm_pkg::CMD_READ, a, n, 1'($urandom), {$urandom, $urandom});
    if (pick < 85)
      return make_access(rcbm_pkg::CMD_WRITE, a, n, 1'($urandom), {$urandom, $urandom});
    return make_access(rcbm_pkg::CMD_LOAD, a, n, 1'($urandom), {$urandom, $urandom});
  endfunction

  task automatic transfer_request(input rcbm_pkg::item_t r);
    while (gaps_on && $urandom_range(99) < 9) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid         = 1'b1;
    req_bus.command       = r.command;
    req_bus.addr          = r.addr;
    req_bus.region_length = r.region_length;
    req_bus.region_flags  = r.region_flags;
    req_bus.access_bytes  = r.nbytes;
    req_bus.fetch         = r.fetch;
    req_bus.write_data    = r.write_data;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic send_request(input rcbm_pkg::item_t r);
    rcbm_pkg::item_t fill;
    if (sb.reads_unwritten(r)) begin
      fill = make_access(rcbm_pkg::CMD_LOAD, r.addr, rcbm_pkg::NBYTES_W'(rcbm_pkg::MAX_ACCESS),
                         1'($urandom), {$urandom, $urandom});
      transfer_request(fill);
    end
    transfer_request(r);
  endtask

  task automatic drain_responses();
    req_bus.valid = 1'b0;
    do @(negedge clk_i); while (sb.awaited_responses.size() != 0);
  endtask

  initial begin
    sb = new();
    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.command       = rcbm_pkg::CMD_INSERT;
    req_bus.addr          = '0;
    req_bus.region_length = '0;
    req_bus.region_flags  = '0;
    req_bus.access_bytes  = '0;
    req_bus.fetch         = 1'b0;
    req_bus.write_data    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Region table: one-byte region, edge and enclosing overlaps, every permission set.
    send_request(make_insert(16'h0000, 16'h0000, ALLOW_R | ALLOW_W | ALLOW_X));
    send_request(make_insert(16'h0001, 16'h1FFE, ALLOW_R | ALLOW_W));
    send_request(make_insert(16'h1FFF, 16'h0005, ALLOW_R));
    send_request(make_insert(16'h2000, rcbm_pkg::LEN_W'($urandom_range(16'h1FFF)),
                             ALLOW_R | ALLOW_X));
    send_request(make_insert(16'h4000, rcbm_pkg::LEN_W'($urandom_range(16'h1FFF)), ALLOW_R));
    send_request(make_insert(16'h3FF0, 16'h0020, ALLOW_W));
    send_request(make_insert(16'h6000, rcbm_pkg::LEN_W'($urandom_range(16'h1FFF)),
                             ALLOW_W | ALLOW_X));
    send_request(make_insert(16'h8000, rcbm_pkg::LEN_W'($urandom_range(16'h1FFF)), ALLOW_W));
    send_request(make_insert(16'hA000, rcbm_pkg::LEN_W'($urandom_range(16'h1FFF)), ALLOW_X));
    send_request(make_insert(16'hF000, 16'h0FFF, ALLOW_NONE));
    send_request(make_insert(16'hC000, 16'hFFFF, ALLOW_R));
    send_request(make_insert(16'hC000, 16'h0000, ALLOW_R));

    // Accesses: address wrap, lengths zero and above eight, spill past a region end,
    // and each refusal in its check order.
    send_request(make_access(rcbm_pkg::CMD_LOAD, 16'hFFFC, 4'd8, 1'b0, 64'h0123_4567_89AB_CDEF));
    send_request(make_access(rcbm_pkg::CMD_WRITE, 16'h0004, 4'd8, 1'b0, '1));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'h0000, 4'd8, 1'b1, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'h0000, 4'd0, 1'b0, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'h0004, 4'd15, 1'b0, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'h0004, 4'd4, 1'b1, '0));
    send_request(make_access(rcbm_pkg::CMD_WRITE, 16'h1FFD, 4'd8, 1'b0, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'h2000, 4'd4, 1'b1, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'h6000, 4'd8, 1'b0, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'hA000, 4'd8, 1'b1, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'hFFFF, 4'd1, 1'b0, '0));
    send_request(make_access(rcbm_pkg::CMD_READ, 16'hC000, 4'd8, 1'b0, '0));
    send_request(make_access(rcbm_pkg::CMD_WRITE, 16'h4000, 4'd8, 1'b0, {$urandom, $urandom}));
    send_request(make_access(rcbm_pkg::CMD_WRITE, 16'h8000, 4'd0, 1'b1, {$urandom, $urandom}));
    send_request(make_access(rcbm_pkg::CMD_LOAD, 16'hE000, 4'd15, 1'b1, {$urandom, $urandom}));
    drain_responses();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 300 && i < 500);
      if (i == 700) drain_responses();
      send_request(random_item());
    end
    gaps_on = 1'b1;
    drain_responses();
    repeat (8) @(negedge clk_i);

    if (sb.errors == 0) begin
      $display("region_checked_byte_memory_unit test passed");
    end else begin
      $display("region_checked_byte_memory_unit test failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/rcbm_pkg.sv
rtl/core/rcbm_req_if.sv
rtl/core/rcbm_rsp_if.sv
rtl/core/region_checked_byte_memory_unit.sv
rtl/core/rcbm_checker.sv
tb/testbench.sv
